// ===== design/tbcw_pkg.sv =====
// shared types, constants and the key table for the table block cipher word block
package tbcw_pkg;

    typedef logic [31:0] t_word;
    typedef logic [255:0][31:0] t_key_table;

    typedef enum logic [0:0] {
        CFG_CIPHER_KEY   = 1'b0,
        CFG_DECRYPT_MODE = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic step;
        logic first;
        logic decrypt;
    } t_step_ctrl;

    localparam t_word MIX_INIT  = 32'hEEEE_EEEE;
    localparam t_word KEY_ADD   = 32'h1111_1111;
    localparam t_word LCG_START = 32'h0010_0001;
    localparam t_word LCG_MOD   = 32'h002A_AAAB;
    localparam t_word LCG_MUL   = 32'd125;
    localparam t_word LCG_INC   = 32'd3;
    localparam t_word MIX_INC   = 32'd3;
    localparam int    ROT_LEFT  = 'h15;
    localparam int    ROT_RIGHT = 'h0B;
    localparam int    MIX_SHIFT = 5;
    localparam int    TABLE_DEPTH = 256;
    localparam int    LCG_GROUP   = 5;

    // elaboration-time generator, keeps the last word of each group of five
    function automatic t_key_table f_build_key_table();
        t_key_table tbl;
        t_word      s;
        t_word      hi;
        s   = LCG_START;
        hi  = '0;
        tbl = '0;
        for (int a = 0; a < TABLE_DEPTH; a++) begin
            for (int g = 0; g < LCG_GROUP; g++) begin
                s  = (s * LCG_MUL + LCG_INC) % LCG_MOD;
                hi = {s[15:0], 16'h0000};
                s  = (s * LCG_MUL + LCG_INC) % LCG_MOD;
                if (g == LCG_GROUP - 1) begin
                    tbl[a] = hi | {16'h0000, s[15:0]};
                end
            end
        end
        return tbl;
    endfunction

    localparam t_key_table KEY_TABLE = f_build_key_table();

endpackage

// ===== design/tbcw_core.sv =====
// running key and mix state with the combinational word transform
module tbcw_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tbcw_pkg::t_step_ctrl i_ctrl,
    input  tbcw_pkg::t_word     i_word,
    input  tbcw_pkg::t_word     i_cipher_key,
    output tbcw_pkg::t_word     o_result
);
    import tbcw_pkg::*;

    t_word r_key;
    t_word r_mix;
    t_word n_key;
    t_word n_mix;
    t_word key_cur;
    t_word mix_cur;
    t_word mix_add;
    t_word result;
    t_word plain;

    always_comb begin
        key_cur = i_ctrl.first ? i_cipher_key : r_key;
        mix_cur = i_ctrl.first ? MIX_INIT : r_mix;
        mix_add = mix_cur + KEY_TABLE[key_cur[7:0]];
        result  = i_word ^ (key_cur + mix_add);
        plain   = i_ctrl.decrypt ? result : i_word;
        n_key   = ((~key_cur << ROT_LEFT) + KEY_ADD) | (key_cur >> ROT_RIGHT);
        n_mix   = plain + mix_add + (mix_add << MIX_SHIFT) + MIX_INC;
    end

    assign o_result = result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_mix <= MIX_INIT;
        end else if (i_ctrl.step) begin
            r_key <= n_key;
            r_mix <= n_mix;
        end
    end

endmodule

// ===== design/table_block_cipher_word.sv =====
// top level of the table block cipher word block
//
//  channel   direction  handshake              payload
//  input     in         i_valid / o_ready      i_data_word, i_first_word
//  result    out        o_valid / i_ready      o_result_word
//  config    in         i_cfg_wr_en            i_cfg_index, i_cfg_wdata
//
// one item per cycle while the output is not stalled; an item is held in the input register and
// its result is then registered in the output register
// the key table lookup and the mix adds sit between those two registers
// synchronous active-low reset clears key to 0 and mix to 0xEEEEEEEE
// a stalled output holds its item; the input register keeps taking items
// while it is empty or the output register can move
module table_block_cipher_word (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tbcw_pkg::t_word     i_data_word,
    input  logic                i_first_word,
    output logic                o_valid,
    input  logic                i_ready,
    output tbcw_pkg::t_word     o_result_word,
    input  logic                i_cfg_wr_en,
    input  tbcw_pkg::t_cfg_index i_cfg_index,
    input  tbcw_pkg::t_word     i_cfg_wdata
);
    import tbcw_pkg::*;

    t_word      r_cipher_key;
    logic       r_decrypt;
    logic       r_in_valid;
    t_word      r_in_word;
    logic       r_in_first;
    logic       r_out_valid;
    t_word      r_out_word;
    logic       advance;
    t_step_ctrl ctrl;
    t_word      result;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign o_valid = r_out_valid;
    assign o_result_word = r_out_word;

    always_comb begin
        ctrl.step    = advance;
        ctrl.first   = r_in_first;
        ctrl.decrypt = r_decrypt;
    end

    tbcw_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_word       (r_in_word),
        .i_cipher_key (r_cipher_key),
        .o_result     (result)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_key <= '0;
            r_decrypt    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CIPHER_KEY:   r_cipher_key <= i_cfg_wdata;
                CFG_DECRYPT_MODE: r_decrypt    <= i_cfg_wdata[0];
                default:          r_decrypt    <= r_decrypt;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_word  <= i_data_word;
            r_in_first <= i_first_word;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= result;
        end
    end

endmodule

// ===== test/tb_top.sv =====
// testbench for table_block_cipher_word: directed rows and random blocks checked against a cipher predictor
`timescale 1ns / 100ps

module tb_top;
    import tbcw_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_GAP = 60;

    typedef enum logic [1:0] {
        DIR_WORD,
        DIR_KEY,
        DIR_MODE
    } t_dir_kind;

    typedef struct packed {
        t_dir_kind kind;
        t_word     value;
        logic      first;
    } t_dir_row;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    t_word               in_data;
    logic                in_first;
    logic                out_valid;
    logic                out_ready;
    t_word               out_word;
    logic                cfg_wr_en;
    t_cfg_index          cfg_index;
    t_word               cfg_wdata;

    t_word cipher_tbl [256];
    t_word run_key;
    t_word run_mix;
    t_word cfg_key;
    logic  cfg_decrypt;

    t_word pending_words [$];
    int    mismatch_cnt;
    int    cycle_cnt;
    int    tx_idle_pct;
    int    rx_stall_pct;
    int    hold_req;
    int    hold_left;

    // stress at the edges of the key and data, words before any first word,
    // a key write in the middle of a block and back-to-back first words
    t_dir_row dir_rows [22] = '{
        '{DIR_WORD, 32'h0000_0000, 1'b0},
        '{DIR_WORD, 32'hFFFF_FFFF, 1'b0},
        '{DIR_WORD, 32'h1234_5678, 1'b0},
        '{DIR_KEY,  32'hFFFF_FFFF, 1'b0},
        '{DIR_WORD, 32'hFFFF_FFFF, 1'b1},
        '{DIR_WORD, 32'h0000_0000, 1'b0},
        '{DIR_WORD, 32'h8000_0001, 1'b0},
        '{DIR_KEY,  32'h0000_0000, 1'b0},
        '{DIR_WORD, 32'hA5A5_A5A5, 1'b0},
        '{DIR_WORD, 32'h5A5A_5A5A, 1'b1},
        '{DIR_MODE, 32'h0000_0001, 1'b0},
        '{DIR_WORD, 32'h0000_0000, 1'b1},
        '{DIR_WORD, 32'hFFFF_FFFF, 1'b0},
        '{DIR_WORD, 32'h0000_0000, 1'b0},
        '{DIR_KEY,  32'h1234_56FF, 1'b0},
        '{DIR_WORD, 32'h7FFF_FFFE, 1'b1},
        '{DIR_WORD, 32'h0000_0001, 1'b1},
        '{DIR_WORD, 32'hFEDC_BA98, 1'b0},
        '{DIR_MODE, 32'h0000_0000, 1'b0},
        '{DIR_WORD, 32'hDEAD_BEEF, 1'b1},
        '{DIR_WORD, 32'hFFFF_FFFF, 1'b1},
        '{DIR_WORD, 32'h0000_0000, 1'b0}
    };

    table_block_cipher_word DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (in_valid),
        .o_ready       (in_ready),
        .i_data_word   (in_data),
        .i_first_word  (in_first),
        .o_valid       (out_valid),
        .i_ready       (out_ready),
        .o_result_word (out_word),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_wdata   (cfg_wdata)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // key table: last word of each group of five generator pairs
    function automatic void build_cipher_table();
        longint unsigned seed;
        t_word           upper;
        seed = LCG_START;
        for (int a = 0; a < 256; a++) begin
            for (int g = 0; g < 5; g++) begin
                seed  = (seed * LCG_MUL + LCG_INC) % LCG_MOD;
                upper = {seed[15:0], 16'h0000};
                seed  = (seed * LCG_MUL + LCG_INC) % LCG_MOD;
                if (g == 4) begin
                    cipher_tbl[a] = upper | {16'h0000, seed[15:0]};
                end
            end
        end
    endfunction

    function automatic t_word next_cipher_word(input t_word data, input logic first);
        t_word res;
        t_word plain;
        t_word old_key;
        if (first) begin
            run_key = cfg_key;
            run_mix = MIX_INIT;
        end
        run_mix = run_mix + cipher_tbl[run_key[7:0]];
        res     = data ^ (run_key + run_mix);
        old_key = run_key;
        run_key = (((~old_key) << ROT_LEFT) + KEY_ADD) | (old_key >> ROT_RIGHT);
        plain   = cfg_decrypt ? res : data;
        run_mix = plain + run_mix + (run_mix << MIX_SHIFT) + MIX_INC;
        return res;
    endfunction

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("table_block_cipher_word regression: fail");
            $finish;
        end
    end

    // result check and input prediction
    always @(posedge clk) begin
        t_word exp_word;
        if (rst_n && out_valid && out_ready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected result %08h, nothing expected", $time, out_word);
                mismatch_cnt++;
            end else begin
                exp_word = pending_words.pop_front();
                if (out_word !== exp_word) begin
                    $display("%0t: result_word mismatch: expected %08h, got %08h",
                             $time, exp_word, out_word);
                    mismatch_cnt++;
                end
            end
        end
        if (rst_n && in_valid && in_ready) begin
            pending_words.push_back(next_cipher_word(in_data, in_first));
        end
    end

    // receiver side: random stalls plus a long hold-off on request
    always @(negedge clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic push_word(input t_word data, input logic first);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= data;
        in_first <= first;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input t_word value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == CFG_CIPHER_KEY) begin
            cfg_key = value;
        end else begin
            cfg_decrypt = value[0];
        end
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input int n_items,
                             input t_word key, input logic decrypt, input logic hold);
        int sent;
        int len;
        sent = 0;
        wait_idle();
        write_reg(CFG_CIPHER_KEY, key);
        write_reg(CFG_DECRYPT_MODE, {31'b0, decrypt});
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (hold) begin
            hold_req = HOLD_CYCLES;
        end
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                wait_idle();
                write_reg(CFG_CIPHER_KEY, $urandom);
                if ($urandom_range(3) == 0) begin
                    write_reg(CFG_DECRYPT_MODE, {31'b0, 1'($urandom_range(1))});
                end
            end
            if ($urandom_range(99) < 85) begin
                len = $urandom_range(16, 1);
                for (int i = 0; i < len; i++) push_word($urandom, i == 0);
            end else begin
                len = $urandom_range(6, 1);
                for (int i = 0; i < len; i++) push_word($urandom, 1'($urandom_range(1)));
            end
            sent += len;
        end
    endtask

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        in_first     = 1'b0;
        out_ready    = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_CIPHER_KEY;
        cfg_wdata    = '0;
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req     = 0;
        hold_left    = 0;
        run_key      = '0;
        run_mix      = MIX_INIT;
        cfg_key      = '0;
        cfg_decrypt  = 1'b0;
        build_cipher_table();

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                DIR_WORD: begin
                    push_word(dir_rows[i].value, dir_rows[i].first);
                end
                DIR_KEY: begin
                    wait_idle();
                    write_reg(CFG_CIPHER_KEY, dir_rows[i].value);
                end
                default: begin
                    wait_idle();
                    write_reg(CFG_DECRYPT_MODE, dir_rows[i].value);
                end
            endcase
        end

        run_phase(0,  0,  190, 32'h0000_0000, 1'b0, 1'b0);
        run_phase(83, 0,  190, 32'hFFFF_FFFF, 1'b1, 1'b0);
        run_phase(0,  83, 190, $urandom,      1'b0, 1'b0);
        run_phase(37, 37, 190, $urandom,      1'b1, 1'b0);
        run_phase(0,  0,  190, $urandom,      1'b0, 1'b1);
        run_phase(37, 37, 190, 32'h0000_00FF, 1'b1, 1'b0);
        run_phase(83, 0,  180, $urandom,      1'b0, 1'b0);
        run_phase(0,  83, 180, 32'hFFFF_FF00, 1'b1, 1'b0);

        wait_idle();
        repeat (10) @(negedge clk);
        if (mismatch_cnt == 0 && pending_words.size() == 0) begin
            $display("table_block_cipher_word regression: pass");
        end else begin
            $display("table_block_cipher_word regression: fail");
        end
        $finish;
    end

endmodule
